// ===== rtl/core/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and small helpers of the playfair stream encryptor.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SQ_SIZE = 25;
  localparam int SQ_SIDE = 5;
  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_PUSH = 3;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_MAX = 5'd25;
  localparam logic [4:0] SQ_FULL = 5'd25;
  localparam logic [2:0] LAST_IDX = 3'd4;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_TEXT  = 2'd1,
    CMD_END   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_APPLY
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_KEY,
    ACT_HOLD,
    ACT_PAIR_KEEP,
    ACT_PAIR,
    ACT_END_FLUSH,
    ACT_END
  } act_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [4:0] letter;
  } in_item_t;

  typedef struct packed {
    logic [4:0] cipher_letter;
    logic       end_marker;
  } out_item_t;

  // broadcast to every cell of the square
  typedef struct packed {
    logic       clear;
    logic       key_write;
    logic [4:0] placed;
    logic [4:0] pos;
    logic [4:0] key_letter;
    logic [4:0] cmp_a;
    logic [4:0] cmp_b;
    logic [4:0] rd_a;
    logic [4:0] rd_b;
  } cell_ctrl_t;

  // per-cell compare hits and gated read data
  typedef struct packed {
    logic       hit_a;
    logic       hit_b;
    logic [4:0] data_a;
    logic [4:0] data_b;
  } cell_stat_t;

  // alphabet order without J
  function automatic logic [4:0] alpha_letter(input logic [4:0] idx);
    alpha_letter = (idx < LETTER_J) ? idx : 5'(idx + 5'd1);
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] pos);
    logic [2:0] r;
    if (pos >= 5'd20) r = 3'd4;
    else if (pos >= 5'd15) r = 3'd3;
    else if (pos >= 5'd10) r = 3'd2;
    else if (pos >= 5'd5) r = 3'd1;
    else r = 3'd0;
    pos_row = r;
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] pos);
    logic [2:0] r;
    logic [4:0] base;
    r = pos_row(pos);
    base = 5'({2'b00, r} * 5'(SQ_SIDE));
    pos_col = 3'(pos - base);
  endfunction

  function automatic logic [4:0] rc_pos(input logic [2:0] row, input logic [2:0] col);
    rc_pos = 5'({2'b00, row} * 5'(SQ_SIDE)) + {2'b00, col};
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    wrap_inc = (v == LAST_IDX) ? 3'd0 : 3'(v + 3'd1);
  endfunction

endpackage

// ===== rtl/core/pfe_cell.sv =====
// ----------------------------------------------------------------------------
// pfe_cell
// One place of the key square: holds a letter, compares it, shifts it up.
// ----------------------------------------------------------------------------
module pfe_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         idx,
  input  logic [4:0]         prev_letter,
  input  pfe_pkg::cell_ctrl_t ctrl,
  output logic [4:0]         letter,
  output pfe_pkg::cell_stat_t stat
);
  import pfe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      letter <= alpha_letter(idx);
    end else if (ctrl.key_write) begin
      if (idx == ctrl.placed) begin
        letter <= ctrl.key_letter;
      end else if (idx > ctrl.placed && idx <= ctrl.pos) begin
        // make room for the new key letter
        letter <= prev_letter;
      end
    end
  end

  always_comb begin
    stat.hit_a  = (letter == ctrl.cmp_a);
    stat.hit_b  = (letter == ctrl.cmp_b);
    stat.data_a = (idx == ctrl.rd_a) ? letter : 5'd0;
    stat.data_b = (idx == ctrl.rd_b) ? letter : 5'd0;
  end

endmodule

// ===== rtl/core/pfe_queue.sv =====
// ----------------------------------------------------------------------------
// pfe_queue
// Result queue: takes up to three results a cycle, gives one a cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module pfe_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [1:0]                             push_n,
  input  pfe_pkg::out_item_t [pfe_pkg::MAX_PUSH-1:0] push_data,
  output logic [3:0]                             count,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output pfe_pkg::out_item_t                     out_data
);
  import pfe_pkg::*;

  out_item_t  mem [QUEUE_DEPTH];
  logic [2:0] wr_ptr;
  logic [2:0] rd_ptr;
  logic       pop;

  assign out_valid = (count != 4'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 3'd0;
      rd_ptr <= 3'd0;
      count  <= 4'd0;
    end else begin
      wr_ptr <= wr_ptr + {1'b0, push_n};
      rd_ptr <= rd_ptr + {2'b00, pop};
      count  <= count + {2'b00, push_n} - {3'b000, pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < push_n) begin
        mem[wr_ptr + 3'(i)] <= push_data[i];
      end
    end
  end

endmodule

// ===== rtl/core/playfair_stream_encryptor_top.sv =====
// ----------------------------------------------------------------------------
// playfair_stream_encryptor_top
// Playfair encryption of a letter stream with a key square built in-line.
// ----------------------------------------------------------------------------
// Each request carries a command and a letter index (A=0 .. Z=25, J folded
// onto I). Key letters build the 5x5 square, clear restores the plain
// alphabet, plaintext letters are paired and encrypted, end of message
// flushes a lone held letter against X and closes with an end marker.
// A request passes through a lookup cycle, in which every cell of the
// 25-place square compares its letter against the two letters of interest,
// and an apply cycle, in which the cells shift for a key letter or give up
// the two cipher letters. A new request is taken in the apply cycle of the
// previous one, so requests overlap there. Results go into an eight-entry
// queue; a request is only taken while the queue has room for the three
// results the worst case gives, so a slow consumer stalls the request side.
// Letters above Z are dropped without a result. There is no clearing pass
// after reset: the cells load the plain alphabet directly from reset.
// ----------------------------------------------------------------------------
module playfair_stream_encryptor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                letter_valid,
  output logic                letter_ready,
  input  pfe_pkg::in_item_t   letter_item,
  output logic                cipher_valid,
  input  logic                cipher_ready,
  output pfe_pkg::out_item_t  cipher_item
);
  import pfe_pkg::*;

  // control state
  state_t     state;
  state_t     state_next;
  act_t       act;
  act_t       act_next;
  logic [4:0] placed;
  logic [4:0] held_letter;
  logic       held_valid;

  // request register
  cmd_t       item_cmd;
  logic [4:0] item_letter;

  // lookup results for the apply cycle
  logic [2:0] ra;
  logic [2:0] ca;
  logic [2:0] rb;
  logic [2:0] cb;
  logic [4:0] key_pos;
  logic [4:0] op_letter;

  // cell row
  cell_ctrl_t ctrl;
  logic [4:0] cell_letter [SQ_SIZE];
  cell_stat_t cell_stat   [SQ_SIZE];
  logic [4:0] pos_a;
  logic [4:0] pos_b;
  logic [4:0] rd_a_letter;
  logic [4:0] rd_b_letter;

  // lookup-cycle decode
  logic [4:0] l_map;
  logic       l_bad;
  logic       held_same;

  // result side
  logic [1:0] push_n;
  out_item_t  [MAX_PUSH-1:0] push_data;
  logic [3:0] q_count;
  logic       accept;

  // ---- request acceptance ----
  // taken in idle or in the apply cycle, while the queue can absorb three
  // results on top of what this apply cycle pushes
  assign letter_ready = (state == ST_IDLE || state == ST_APPLY) &&
                        ((q_count + {2'b00, push_n}) <=
                         4'(QUEUE_DEPTH - MAX_PUSH));
  assign accept = letter_valid && letter_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd    <= letter_item.cmd;
      item_letter <= letter_item.letter;
    end
  end

  // ---- lookup decode ----
  assign l_map     = (item_letter == LETTER_J) ? LETTER_I : item_letter;
  assign l_bad     = (item_letter > LETTER_MAX);
  assign held_same = (held_letter == l_map);

  always_comb begin
    act_next = ACT_NONE;
    case (item_cmd)
      CMD_CLEAR: act_next = ACT_CLEAR;
      CMD_END:   act_next = held_valid ? ACT_END_FLUSH : ACT_END;
      CMD_KEY: begin
        // a full square or an already placed letter leaves things alone
        if (!l_bad && placed < SQ_FULL && pos_a >= placed) begin
          act_next = ACT_KEY;
        end
      end
      CMD_TEXT: begin
        if (!l_bad) begin
          if (!held_valid) begin
            act_next = ACT_HOLD;
          end else if (held_same) begin
            act_next = ACT_PAIR_KEEP;
          end else begin
            act_next = ACT_PAIR;
          end
        end
      end
      default: act_next = ACT_NONE;
    endcase
  end

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   state_next = accept ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_next = ST_APPLY;
      ST_APPLY:  state_next = accept ? ST_LOOKUP : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---- lookup registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= ACT_NONE;
    end else if (state == ST_LOOKUP) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      ra        <= pos_row(pos_a);
      ca        <= pos_col(pos_a);
      rb        <= pos_row(pos_b);
      cb        <= pos_col(pos_b);
      key_pos   <= pos_a;
      op_letter <= l_map;
    end
  end

  // ---- apply: square count and held letter ----
  always_ff @(posedge clk) begin
    if (rst) begin
      placed      <= 5'd0;
      held_letter <= 5'd0;
      held_valid  <= 1'b0;
    end else if (state == ST_APPLY) begin
      case (act)
        ACT_CLEAR: placed <= 5'd0;
        ACT_KEY:   placed <= placed + 5'd1;
        ACT_HOLD: begin
          held_letter <= op_letter;
          held_valid  <= 1'b1;
        end
        ACT_PAIR, ACT_END_FLUSH, ACT_END: begin
          held_letter <= 5'd0;
          held_valid  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---- cell control ----
  always_comb begin
    logic [4:0] qa;
    logic [4:0] qb;
    // row rule, column rule, else rectangle rule
    if (ra == rb) begin
      qa = rc_pos(ra, wrap_inc(ca));
      qb = rc_pos(rb, wrap_inc(cb));
    end else if (ca == cb) begin
      qa = rc_pos(wrap_inc(ra), ca);
      qb = rc_pos(wrap_inc(rb), cb);
    end else begin
      qa = rc_pos(ra, cb);
      qb = rc_pos(rb, ca);
    end
    ctrl.clear      = (state == ST_APPLY) && (act == ACT_CLEAR);
    ctrl.key_write  = (state == ST_APPLY) && (act == ACT_KEY);
    ctrl.placed     = placed;
    ctrl.pos        = key_pos;
    ctrl.key_letter = op_letter;
    // a key letter looks itself up; a pair looks up held and partner
    ctrl.cmp_a      = (item_cmd == CMD_KEY) ? l_map : held_letter;
    ctrl.cmp_b      = (item_cmd == CMD_END || held_same) ? LETTER_X : l_map;
    ctrl.rd_a       = qa;
    ctrl.rd_b       = qb;
  end

  // ---- the square: a row of cells, each fed by its lower neighbour ----
  for (genvar k = 0; k < SQ_SIZE; k++) begin : g_cell
    logic [4:0] prev;
    if (k == 0) begin : g_first
      assign prev = 5'd0;
    end else begin : g_rest
      assign prev = cell_letter[k-1];
    end
    pfe_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (5'(k)),
      .prev_letter (prev),
      .ctrl        (ctrl),
      .letter      (cell_letter[k]),
      .stat        (cell_stat[k])
    );
  end

  // positions and read data gathered from the row; hits are one-hot
  always_comb begin
    pos_a       = 5'd0;
    pos_b       = 5'd0;
    rd_a_letter = 5'd0;
    rd_b_letter = 5'd0;
    for (int k = 0; k < SQ_SIZE; k++) begin
      pos_a       = pos_a | (cell_stat[k].hit_a ? 5'(k) : 5'd0);
      pos_b       = pos_b | (cell_stat[k].hit_b ? 5'(k) : 5'd0);
      rd_a_letter = rd_a_letter | cell_stat[k].data_a;
      rd_b_letter = rd_b_letter | cell_stat[k].data_b;
    end
  end

  // ---- results ----
  always_comb begin
    push_n = 2'd0;
    if (state == ST_APPLY) begin
      case (act)
        ACT_PAIR, ACT_PAIR_KEEP: push_n = 2'd2;
        ACT_END_FLUSH:           push_n = 2'd3;
        ACT_END:                 push_n = 2'd1;
        default:                 push_n = 2'd0;
      endcase
    end
    push_data[0] = (act == ACT_END) ? out_item_t'{5'd0, 1'b1}
                                    : out_item_t'{rd_a_letter, 1'b0};
    push_data[1] = out_item_t'{rd_b_letter, 1'b0};
    push_data[2] = out_item_t'{5'd0, 1'b1};
  end

  pfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .count     (q_count),
    .out_valid (cipher_valid),
    .out_ready (cipher_ready),
    .out_data  (cipher_item)
  );

endmodule

// ===== test/playfair_stream_encryptor_top_test.sv =====
// ----------------------------------------------------------------------------
// playfair_stream_encryptor_top_test
// Self-checking bench for the playfair stream encryptor. A clocked driver
// feeds requests from a staged queue, a clocked monitor checks every cipher
// result against a predicted stream kept by an in-bench copy of the square.
// ----------------------------------------------------------------------------
module playfair_stream_encryptor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfe_pkg::*;

  // one staged request with its idling mode and drain flag
  typedef struct {
    in_item_t req;
    int       mode;
    bit       drain;
  } staged_req_t;

  // idling modes of a phase
  localparam int MODE_FREE   = 0;
  localparam int MODE_TX_GAP = 1;
  localparam int MODE_RX_STL = 2;
  localparam int MODE_BOTH   = 3;

  localparam int PHASE_LEN    = 40;
  localparam int RANDOM_ITEMS = 245;
  localparam int TAIL_CYCLES  = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      letter_valid = 1'b0;
  logic      letter_ready;
  in_item_t  letter_item = '0;
  logic      cipher_valid;
  logic      cipher_ready = 1'b0;
  out_item_t cipher_item;

  staged_req_t request_q[$];
  out_item_t   cipher_due_q[$];

  int staged;
  int expected_total;
  int results_seen;
  int mismatch_count;
  int cur_mode;

  // in-bench copy of the square and the pairing state
  logic [4:0] sq_model [SQ_SIZE];
  logic [4:0] key_count;
  logic [4:0] held_l;
  logic       held_v;

  playfair_stream_encryptor_top dut (
    .clk          (clk),
    .rst          (rst),
    .letter_valid (letter_valid),
    .letter_ready (letter_ready),
    .letter_item  (letter_item),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher_item  (cipher_item)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // plain alphabet with J left out, no key letters placed
  task automatic square_reset();
    int n;
    n = 0;
    for (int k = 0; k < 26; k++) begin
      if (k != int'(LETTER_J)) begin
        sq_model[n] = 5'(k);
        n++;
      end
    end
    key_count = '0;
  endtask

  function automatic int find_letter(input logic [4:0] l);
    for (int k = 0; k < SQ_SIZE; k++)
      if (sq_model[k] == l) return k;
    return 0;
  endfunction

  task automatic due_push(input logic [4:0] l, input logic mark);
    out_item_t r;
    r.cipher_letter = l;
    r.end_marker = mark;
    cipher_due_q = {cipher_due_q, r};
    expected_total++;
  endtask

  // row rule or column rule, both wrapping, else rectangle rule
  task automatic encrypt_pair(input logic [4:0] a, input logic [4:0] b);
    int pa, pb, ra, ca, rb, cb, qa, qb;
    pa = find_letter(a);
    pb = find_letter(b);
    ra = pa / SQ_SIDE;
    ca = pa % SQ_SIDE;
    rb = pb / SQ_SIDE;
    cb = pb % SQ_SIDE;
    if (ra == rb) begin
      qa = ra * SQ_SIDE + (ca + 1) % SQ_SIDE;
      qb = rb * SQ_SIDE + (cb + 1) % SQ_SIDE;
    end else if (ca == cb) begin
      qa = ((ra + 1) % SQ_SIDE) * SQ_SIDE + ca;
      qb = ((rb + 1) % SQ_SIDE) * SQ_SIDE + cb;
    end else begin
      qa = ra * SQ_SIDE + cb;
      qb = rb * SQ_SIDE + ca;
    end
    due_push(sq_model[qa], 1'b0);
    due_push(sq_model[qb], 1'b0);
  endtask

  // works out the cipher results one accepted request causes
  task automatic encrypt_request(input in_item_t r);
    logic [4:0] l;
    int p;
    l = r.letter;
    case (r.cmd)
      CMD_CLEAR: begin
        // a held plaintext letter survives a clear
        square_reset();
      end
      CMD_END: begin
        if (held_v) encrypt_pair(held_l, LETTER_X);
        held_v = 1'b0;
        held_l = '0;
        due_push('0, 1'b1);
      end
      default: begin
        if (l <= LETTER_MAX) begin
          if (l == LETTER_J) l = LETTER_I;
          if (r.cmd == CMD_KEY) begin
            p = find_letter(l);
            // full square or letter already placed: nothing happens
            if (key_count < SQ_FULL && p >= int'(key_count)) begin
              for (int k = p; k > int'(key_count); k--) sq_model[k] = sq_model[k - 1];
              sq_model[key_count] = l;
              key_count++;
            end
          end else if (!held_v) begin
            held_l = l;
            held_v = 1'b1;
          end else if (held_l == l) begin
            // repeated letter goes with X and stays held
            encrypt_pair(held_l, LETTER_X);
          end else begin
            encrypt_pair(held_l, l);
            held_v = 1'b0;
            held_l = '0;
          end
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // driver: presents staged requests, predicts on acceptance
  // --------------------------------------------------------------------------
  function automatic int tx_idle_pct(input int mode);
    return (mode == MODE_TX_GAP) ? 75 : (mode == MODE_BOTH) ? 27 : 0;
  endfunction

  function automatic int rx_stall_pct(input int mode);
    return (mode == MODE_RX_STL) ? 75 : (mode == MODE_BOTH) ? 27 : 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      letter_valid <= 1'b0;
      letter_item <= '0;
      cur_mode <= MODE_FREE;
      square_reset();
      held_l = '0;
      held_v = 1'b0;
      expected_total = 0;
    end else begin
      // request taken at this edge
      if (letter_valid && letter_ready) encrypt_request(letter_item);
      if (!letter_valid || letter_ready) begin
        if (request_q.size() == 0) begin
          letter_valid <= 1'b0;
        end else if (request_q[0].drain && results_seen != expected_total) begin
          // hold off until the result stream has caught up
          letter_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < tx_idle_pct(request_q[0].mode)) begin
          letter_valid <= 1'b0;
        end else begin
          letter_valid <= 1'b1;
          letter_item <= request_q[0].req;
          cur_mode <= request_q[0].mode;
          void'(request_q.pop_front());
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure and field-by-field checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cipher_ready <= 1'b0;
      results_seen <= 0;
      mismatch_count = 0;
    end else begin
      cipher_ready <= ($urandom_range(0, 99) >= rx_stall_pct(cur_mode));
      if (cipher_valid && cipher_ready) begin
        if (cipher_due_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: letter %0d end %0b",
                     cipher_item.cipher_letter, cipher_item.end_marker);
          mismatch_count++;
        end else begin
          want = cipher_due_q.pop_front();
          results_seen <= results_seen + 1;
          if (cipher_item.cipher_letter !== want.cipher_letter ||
              cipher_item.end_marker !== want.end_marker) begin
            if (mismatch_count < 10)
              $display("result %0d: expected letter %0d end %0b, got letter %0d end %0b",
                       results_seen, want.cipher_letter, want.end_marker,
                       cipher_item.cipher_letter, cipher_item.end_marker);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic stage(input cmd_t c, input int l);
    staged_req_t e;
    e.req.cmd = c;
    e.req.letter = 5'(l);
    e.mode = (staged / PHASE_LEN) % 4;
    // every phase opens with a drain, plus the odd one at random
    e.drain = (staged % PHASE_LEN == 0) || ($urandom_range(0, 49) == 0);
    request_q = {request_q, e};
    staged++;
  endtask

  // a whole message: optional clear, key letters, text with repeats, usually an end
  task automatic stage_message();
    int nk, nt, l, prev;
    if ($urandom_range(0, 1)) stage(CMD_CLEAR, $urandom_range(0, 31));
    nk = $urandom_range(0, 6);
    for (int k = 0; k < nk; k++) stage(CMD_KEY, $urandom_range(0, 25));
    nt = $urandom_range(1, 12);
    prev = 0;
    for (int t = 0; t < nt; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: l = (t > 0) ? prev : $urandom_range(0, 25);
        3: l = LETTER_X;
        default: l = $urandom_range(0, 25);
      endcase
      // key letters mid-message change the square for the next pair
      if ($urandom_range(0, 9) == 0) stage(CMD_KEY, $urandom_range(0, 25));
      if ($urandom_range(0, 19) == 0) stage(CMD_TEXT, $urandom_range(26, 31));
      stage(CMD_TEXT, l);
      prev = l;
    end
    if ($urandom_range(0, 19) != 0) stage(CMD_END, $urandom_range(0, 31));
  endtask

  // a clear followed by all 25 letters in shuffled order, then overflow keys and a message
  task automatic stage_full_square();
    int letters [SQ_SIZE];
    int j, tmp, n;
    n = 0;
    for (int k = 0; k < 26; k++)
      if (k != int'(LETTER_J)) begin
        letters[n] = k;
        n++;
      end
    for (int k = SQ_SIZE - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = letters[k];
      letters[k] = letters[j];
      letters[j] = tmp;
    end
    stage(CMD_CLEAR, 0);
    foreach (letters[k]) begin
      // I sometimes given as J
      if (letters[k] == int'(LETTER_I) && $urandom_range(0, 1)) stage(CMD_KEY, LETTER_J);
      else stage(CMD_KEY, letters[k]);
    end
    stage(CMD_KEY, $urandom_range(0, 25));
    stage(CMD_KEY, $urandom_range(0, 25));
    stage_message();
  endtask

  initial begin
    staged = 0;

    // directed: the three rules on the plain alphabet, with wraparound
    stage(CMD_TEXT, 0);
    stage(CMD_TEXT, 1);
    stage(CMD_TEXT, 0);
    stage(CMD_TEXT, 5);
    stage(CMD_TEXT, 0);
    stage(CMD_TEXT, 6);
    stage(CMD_TEXT, 4);
    stage(CMD_TEXT, 0);
    stage(CMD_TEXT, 25);
    stage(CMD_TEXT, 20);
    // doubled X, then an end that flushes the held X
    stage(CMD_TEXT, LETTER_X);
    stage(CMD_TEXT, LETTER_X);
    stage(CMD_END, 31);
    // end with nothing held
    stage(CMD_END, 0);
    // letters above Z are dropped
    stage(CMD_TEXT, 31);
    stage(CMD_KEY, 26);
    // J folds onto I, giving a repeated letter
    stage(CMD_TEXT, LETTER_J);
    stage(CMD_TEXT, LETTER_I);
    // clear keeps the held letter
    stage(CMD_CLEAR, 0);
    stage(CMD_TEXT, 2);
    // key letters, including one already placed
    stage(CMD_KEY, LETTER_J);
    stage(CMD_KEY, 10);
    stage(CMD_KEY, LETTER_I);
    stage(CMD_KEY, 25);
    stage(CMD_TEXT, 25);
    stage(CMD_TEXT, 16);
    stage(CMD_END, 0);

    // random: full square once up front, then a mix of segments
    stage_full_square();
    while (staged < 25 + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: stage_full_square();
        1, 2, 3: begin
          for (int k = $urandom_range(1, 4); k > 0; k--)
            stage(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 31));
        end
        default: stage_message();
      endcase
    end
  end

  // reset, then wait for the stream to drain and the tail to pass
  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (request_q.size() != 0 || letter_valid || results_seen != expected_total)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (cipher_due_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("playfair_stream_encryptor_top_test passed");
    end else begin
      $display("playfair_stream_encryptor_top_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("playfair_stream_encryptor_top_test failed");
    $finish;
  end

endmodule
